### sv/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, codes and controller/datapath structs for the
// least-recently-used key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W    = IDX_W;
    localparam int OCC_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CAP_CFG_W = 5;

    localparam logic [CAP_CFG_W-1:0] CAP_RESET = CAP_CFG_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Step strobes from the sequencer to the datapath.
    typedef struct packed {
        logic load_item;
        logic match;
        logic act;
        logic evict;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_stall;
    } t_dp_status;

endpackage

### sv/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_if
// Valid/ready channel interfaces for the cache requests and responses.
// ----------------------------------------------------------------------------
interface lkv_in_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

interface lkv_out_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

### sv/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer that walks one item through match, update, eviction and
// result hand-off.
// ----------------------------------------------------------------------------
module lkv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lkv_pkg::t_dp_status i_status,
    output lkv_pkg::t_dp_cmd    o_cmd
);
    import lkv_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_ACT   = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_item = 1'b1;
                if (i_in_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_ACT;
            end
            S_ACT: begin
                o_cmd.act = 1'b1;
                n_state   = S_EVICT;
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                // Hold the finished result until the output register frees up.
                if (!i_status.out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// Entry store with parallel key match, per-entry recency ranks, occupancy,
// capacity register and the result output register.
// ----------------------------------------------------------------------------
module lkv_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lkv_pkg::CAP_CFG_W-1:0]  i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_command,
    input  logic signed [lkv_pkg::KEY_W-1:0] i_key,
    input  logic signed [lkv_pkg::VAL_W-1:0] i_value,
    input  lkv_pkg::t_dp_cmd               i_cmd,
    output lkv_pkg::t_dp_status            o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_hit,
    output logic signed [lkv_pkg::VAL_W-1:0] o_read_value,
    output logic                           o_evicted,
    output logic signed [lkv_pkg::KEY_W-1:0] o_evicted_key
);
    import lkv_pkg::*;

    logic [CAP_CFG_W-1:0] r_cap;

    // Item being worked on.
    logic                    r_cmd;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_val;

    // Entry store.
    logic signed [KEY_W-1:0] r_keys [CAPACITY];
    logic signed [VAL_W-1:0] r_vals [CAPACITY];
    logic [RANK_W-1:0]       r_rank [CAPACITY];
    logic [CAPACITY-1:0]     r_valid;
    logic [OCC_W-1:0]        r_occ;

    logic [CAPACITY-1:0]     r_match;
    logic                    r_hit;
    logic signed [VAL_W-1:0] r_read_value;
    logic                    r_evicted;
    logic signed [KEY_W-1:0] r_ev_key;

    logic                    r_o_valid;
    logic                    r_o_hit;
    logic signed [VAL_W-1:0] r_o_read_value;
    logic                    r_o_evicted;
    logic signed [KEY_W-1:0] r_o_ev_key;

    logic [CAPACITY-1:0]     match_vec;
    logic [CAPACITY-1:0]     victim_vec;
    logic [CAPACITY-1:0]     free_vec;
    logic [RANK_W-1:0]       match_rank;
    logic signed [VAL_W-1:0] match_val;
    logic signed [KEY_W-1:0] victim_key;
    logic [OCC_W-1:0]        occ_dec;
    logic [RANK_W-1:0]       victim_rank;
    logic [OCC_W-1:0]        eff_cap;
    logic                    store_full;
    logic                    evict_need;

    always_comb begin
        match_rank = '0;
        match_val  = '0;
        victim_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match_vec[i]  = r_valid[i] && (r_keys[i] == r_key);
            victim_vec[i] = r_valid[i] && (r_rank[i] == victim_rank);
            if (r_match[i]) begin
                match_rank = match_rank | r_rank[i];
                match_val  = match_val | r_vals[i];
            end
            if (victim_vec[i]) begin
                victim_key = victim_key | r_keys[i];
            end
        end
    end

    // Ranks of valid entries are a permutation of 0..occupancy-1, so the least
    // recent entry is the one whose rank equals occupancy-1.
    assign occ_dec     = r_occ - OCC_W'(1);
    assign victim_rank = occ_dec[RANK_W-1:0];

    // Lowest clear valid bit, as a one-hot vector.
    assign free_vec   = ~r_valid & (r_valid + CAPACITY'(1));
    assign store_full = (r_occ == OCC_W'(CAPACITY));

    always_comb begin
        priority if (r_cap == '0) begin
            eff_cap = OCC_W'(1);
        end else if (32'(r_cap) > 32'(CAPACITY)) begin
            eff_cap = OCC_W'(CAPACITY);
        end else begin
            eff_cap = OCC_W'(r_cap);
        end
    end

    assign evict_need = (r_cmd == CMD_PUT) && !r_evicted && (r_occ > eff_cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item && i_in_valid) begin
            r_cmd <= i_command;
            r_key <= i_key;
            r_val <= i_value;
        end
        if (i_cmd.match) begin
            r_match <= match_vec;
            r_hit   <= |match_vec;
        end
    end

    // Payload of the entries and the working result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.act) begin
            r_evicted <= 1'b0;
            r_ev_key  <= '0;
            if (r_cmd == CMD_GET) begin
                r_read_value <= r_hit ? match_val : '1;
            end else begin
                r_read_value <= '0;
                if (r_hit) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (r_match[i]) begin
                            r_vals[i] <= r_val;
                        end
                    end
                end else if (store_full) begin
                    // The least recent entry gives its slot to the new key.
                    r_evicted <= 1'b1;
                    r_ev_key  <= victim_key;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (victim_vec[i]) begin
                            r_keys[i] <= r_key;
                            r_vals[i] <= r_val;
                        end
                    end
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (free_vec[i]) begin
                            r_keys[i] <= r_key;
                            r_vals[i] <= r_val;
                        end
                    end
                end
            end
        end else if (i_cmd.evict && evict_need) begin
            r_evicted <= 1'b1;
            r_ev_key  <= victim_key;
        end
    end

    // Valid marks, recency ranks and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.act) begin
            if (r_hit) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (r_match[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < match_rank)) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
            end else if (r_cmd == CMD_PUT) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (store_full ? victim_vec[i] : free_vec[i]) begin
                        r_valid[i] <= 1'b1;
                        r_rank[i]  <= '0;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
                if (!store_full) begin
                    r_occ <= r_occ + OCC_W'(1);
                end
            end
        end else if (i_cmd.evict && evict_need) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (victim_vec[i]) begin
                    r_valid[i] <= 1'b0;
                    r_rank[i]  <= '0;
                end
            end
            r_occ <= occ_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_hit        <= r_hit;
            r_o_read_value <= r_read_value;
            r_o_evicted    <= r_evicted;
            r_o_ev_key     <= r_ev_key;
        end
    end

    assign o_status.out_stall = r_o_valid && !i_out_ready;
    assign o_out_valid        = r_o_valid;
    assign o_hit              = r_o_hit;
    assign o_read_value       = r_o_read_value;
    assign o_evicted          = r_o_evicted;
    assign o_evicted_key      = r_o_ev_key;

endmodule

### sv/lru_key_value_cache.sv
// Sequence: once its item is accepted, the sequencer steps it through match, update,
// eviction and output load, and the result is registered in the output register.
// No new item is taken until the previous one is loaded; a stalled output delays that.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) clears valid marks, ranks, occupancy and the
// output register and sets capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lkv_pkg::CAP_CFG_W-1:0] i_cfg_wdata,
    lkv_in_if.sink                        i_in,
    lkv_out_if.source                     o_out
);
    import lkv_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_in.ready = w_in_ready;

    lkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lkv_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in.valid),
        .i_command     (i_in.command),
        .i_key         (i_in.key),
        .i_value       (i_in.value),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_hit         (o_out.hit),
        .o_read_value  (o_out.read_value),
        .o_evicted     (o_out.evicted),
        .o_evicted_key (o_out.evicted_key)
    );

endmodule

### sv/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks of the cache's sequencing and result encoding.
// ----------------------------------------------------------------------------
module lkv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [lkv_pkg::VAL_W-1:0] i_read_value,
    input logic                          i_evicted,
    input logic signed [lkv_pkg::KEY_W-1:0] i_evicted_key
);
    import lkv_pkg::*;

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Only one item is in work: no request is taken in the cycle after one.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while another is in work");

    // A waiting result stays valid and unchanged until it is taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_read_value) && $stable(i_evicted)
             && $stable(i_evicted_key)))
        else $error("waiting result changed or dropped");

    // Evictions only happen on put, whose read value is zero.
    a_evict_is_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_evicted) |-> (i_read_value == '0))
        else $error("eviction reported with a nonzero read value");

    a_no_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_evicted) |-> (i_evicted_key == '0))
        else $error("evicted key nonzero without an eviction");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_read_value  (o_out.read_value),
    .i_evicted     (o_out.evicted),
    .i_evicted_key (o_out.evicted_key)
);

### verif/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// Watches the request and response channels of the cache, keeps its own
// least-recently-used store to predict every reply, and compares each reply
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lkv_pkg::CAP_CFG_W-1:0] i_cfg_wdata,
    lkv_in_if                             i_req,
    lkv_out_if                            i_rsp,
    output int                            o_fail_count,
    output int                            o_pending
);
    import lkv_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_cache_reply;

    logic [KEY_W-1:0]     slot_key   [CAPACITY];
    logic [VAL_W-1:0]     slot_value [CAPACITY];
    logic                 slot_valid [CAPACITY];
    logic [RANK_W-1:0]    slot_age   [CAPACITY];
    logic [OCC_W-1:0]     fill_level;
    logic [CAP_CFG_W-1:0] capacity_reg;

    t_cache_reply cache_replies[$];
    int           fail_tally    = 0;
    int           reply_backlog = 0;

    assign o_fail_count = fail_tally;
    assign o_pending    = reply_backlog;

    // Entries younger than the touched one age by one; the touched one becomes age zero.
    function automatic void make_newest(input int e);
        logic [RANK_W-1:0] r;
        r = slot_age[e];
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_valid[i] && slot_age[i] < r) begin
                slot_age[i]++;
            end
        end
        slot_age[e] = '0;
    endfunction

    function automatic logic [KEY_W-1:0] drop_oldest();
        int victim;
        victim = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) begin
                victim = i;
            end
        end
        if (victim < 0) begin
            return '0;
        end
        slot_valid[victim] = 1'b0;
        slot_age[victim]   = '0;
        if (fill_level > 0) begin
            fill_level--;
        end
        return slot_key[victim];
    endfunction

    function automatic t_cache_reply cache_access(input logic cmd, input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] value);
        t_cache_reply r;
        int           match;
        int           slot;
        int           eff_cap;
        r       = '0;
        match   = -1;
        slot    = -1;
        eff_cap = int'(capacity_reg);
        if (eff_cap < 1) begin
            eff_cap = 1;
        end
        if (eff_cap > CAPACITY) begin
            eff_cap = CAPACITY;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (match < 0 && slot_valid[i] && slot_key[i] == key) begin
                match = i;
            end
        end
        if (cmd == CMD_GET) begin
            if (match >= 0) begin
                make_newest(match);
                r.read_value = slot_value[match];
            end else begin
                r.read_value = '1;
            end
        end else begin
            if (match >= 0) begin
                slot_value[match] = value;
                make_newest(match);
            end else begin
                // A full store makes room first; that is the one eviction of this put.
                if (fill_level >= CAPACITY) begin
                    r.evicted_key = drop_oldest();
                    r.evicted     = 1'b1;
                end
                for (int i = 0; i < CAPACITY; i++) begin
                    if (slot < 0 && !slot_valid[i]) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_valid[i]) begin
                            slot_age[i]++;
                        end
                    end
                    slot_key[slot]   = key;
                    slot_value[slot] = value;
                    slot_valid[slot] = 1'b1;
                    slot_age[slot]   = '0;
                    fill_level++;
                end
            end
            // A lowered capacity sheds at most one entry per put, updates included.
            if (!r.evicted && fill_level > eff_cap) begin
                r.evicted_key = drop_oldest();
                r.evicted     = 1'b1;
            end
        end
        r.hit = (match >= 0);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expected_v,
                                        input logic [31:0] actual_v);
        if (actual_v !== expected_v) begin
            $error("%s: expected %0d, actual %0d", name, $signed(expected_v), $signed(actual_v));
            fail_tally++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_cache_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_valid[i] = 1'b0;
                slot_age[i]   = '0;
            end
            fill_level   = '0;
            capacity_reg = CAP_RESET;
            cache_replies.delete();
        end else begin
            if (i_cfg_we === 1'b1) begin
                capacity_reg = i_cfg_wdata;
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                cache_replies.push_back(cache_access(i_req.command, i_req.key, i_req.value));
            end
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (cache_replies.size() == 0) begin
                    $error("reply with no item waiting for it");
                    fail_tally++;
                end else begin
                    want = cache_replies.pop_front();
                    check_field("hit", 32'(want.hit), 32'(i_rsp.hit));
                    check_field("read_value", want.read_value, i_rsp.read_value);
                    check_field("evicted", 32'(want.evicted), 32'(i_rsp.evicted));
                    check_field("evicted_key", want.evicted_key, i_rsp.evicted_key);
                end
            end
        end
        reply_backlog = cache_replies.size();
    end

endmodule

### verif/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Drives gets and puts into the cache under several capacity settings, with
// random gaps on both channels and one long response hold-off, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
    import lkv_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 200;
    // The quiet limit lies well above the long response hold-off, so reaching it means a hang.
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 78;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CAP_CFG_W-1:0] cfg_wdata = '0;

    bit req_gaps_on      = 1'b1;
    bit rsp_stalls_on    = 1'b1;
    bit hold_off_pending = 1'b0;

    int fail_count;
    int replies_due;

    lkv_in_if  req_ch ();
    lkv_out_if rsp_ch ();

    lru_key_value_cache dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (req_ch),
        .o_out       (rsp_ch)
    );

    lru_key_value_cache_checker cache_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (replies_due)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic offer_request(input logic cmd, input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] value);
        int gap;
        gap = req_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.command = cmd;
        req_ch.key     = key;
        req_ch.value   = value;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (replies_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_CFG_W-1:0] cap);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = cap;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 11))
            0:       w = 32'h8000_0000;
            1:       w = 32'h7fff_ffff;
            2:       w = '1;
            3:       w = '0;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // Keys come mostly from a pool a little larger than the capacity, so hits,
    // updates and evictions all happen often.
    task automatic run_random_phase(input int cap, input int count, input int hold_at);
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] key;
        int               pool_size;
        pool_size = cap + $urandom_range(1, 8);
        for (int i = 0; i < pool_size; i++) begin
            key_pool.push_back(random_word());
        end
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_off_pending = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                key = $urandom();
            end else begin
                key = key_pool[$urandom_range(0, pool_size - 1)];
            end
            offer_request($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, random_word());
        end
    endtask

    // Response side: a random stall before each item, or one long hold-off on request.
    initial begin : reply_sink
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_off_pending) begin
                stall            = HOLD_CYCLES;
                hold_off_pending = 1'b0;
            end else if (rsp_stalls_on) begin
                stall = $urandom_range(0, 9);
            end else begin
                stall = 0;
            end
            if (stall > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            @(negedge clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int caps[9];
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_GET;
        req_ch.key     = '0;
        req_ch.value   = '0;
        caps = '{1, 0, 31, 8, 17, 16, 3, 5, 12};
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty lookup, extreme keys and values, update, a stored -1
        // that must still report a hit, then a full store taking a new key.
        offer_request(CMD_GET, 32'h0000_0000, 32'h1234_5678);
        offer_request(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
        offer_request(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
        offer_request(CMD_GET, 32'h8000_0000, 32'h0);
        offer_request(CMD_PUT, 32'h8000_0000, 32'hffff_ffff);
        offer_request(CMD_GET, 32'h8000_0000, 32'h0);
        offer_request(CMD_GET, 32'hffff_ffff, 32'h0);
        offer_request(CMD_PUT, 32'hffff_ffff, 32'h0);
        offer_request(CMD_GET, 32'hffff_ffff, 32'hffff_ffff);
        for (int k = 1; k <= 13; k++) begin
            offer_request(CMD_PUT, 32'h1 << k, $urandom());
        end
        offer_request(CMD_PUT, 32'h0000_0000, 32'h5555_aaaa);

        // Capacity lowered while the store is full: later puts shed one entry each.
        set_capacity(5'd2);
        offer_request(CMD_PUT, 32'hffff_ffff, 32'h0000_007b);
        offer_request(CMD_GET, 32'h0000_2000, 32'h0);
        offer_request(CMD_PUT, 32'h0f0f_0f0f, 32'hf0f0_f0f0);

        for (int p = 0; p < 9; p++) begin
            set_capacity(caps[p][CAP_CFG_W-1:0]);
            req_gaps_on   = (p != 3);
            rsp_stalls_on = (p != 3 && p != 6);
            run_random_phase((caps[p] < 1) ? 1 : (caps[p] > CAPACITY) ? CAPACITY : caps[p],
                             PHASE_ITEMS, (p == 1) ? 10 : -1);
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
